[rtl/cst_pkg.sv]
`default_nettype none
package cst_pkg;

    localparam int SECTORS  = 18;
    localparam int CPS      = 1024;
    localparam int PPS      = 4096;

    localparam int ID_W     = 15;
    localparam int CH_W     = $clog2(CPS);
    localparam int SEC_W    = ID_W - CH_W;
    localparam int SC_W     = $clog2(SECTORS);
    localparam int PIDX_W   = $clog2(PPS);
    localparam int CNT_W    = PIDX_W + 1;
    localparam int CS_AW    = SEC_W + CH_W;
    localparam int PT_AW    = SEC_W + PIDX_W;
    localparam int CS_DEPTH = SECTORS * CPS;
    localparam int PT_DEPTH = SECTORS * PPS;

    localparam logic [CNT_W-1:0] START_UNSET = {CNT_W{1'b1}};

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LAST      = 3'd1;
    localparam logic [2:0] ST_NODATA    = 3'd2;
    localparam logic [2:0] ST_BADSECTOR = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] w;
    } interp_req_t;

endpackage
`default_nettype wire

[rtl/cst_interp.sv]
`default_nettype none
module cst_interp import cst_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire interp_req_t req,
    output logic             done,
    output logic [31:0]      result
);

    localparam logic [3:0] U_IDLE = 4'd0;
    localparam logic [3:0] U_D    = 4'd1;
    localparam logic [3:0] U_W    = 4'd2;
    localparam logic [3:0] U_DY   = 4'd3;
    localparam logic [3:0] U_ABS  = 4'd4;
    localparam logic [3:0] U_MUL  = 4'd5;
    localparam logic [3:0] U_DIV  = 4'd6;
    localparam logic [3:0] U_FIN  = 4'd7;
    localparam logic [3:0] U_CORR = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    interp_req_t req_reg, req_next;
    logic [31:0] d_reg, d_next;
    logic [63:0] p_reg, p_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] mag_reg, mag_next;
    logic [33:0] base_reg, base_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;

    logic [33:0] add_a, add_b, add_s;
    logic        add_sub;
    logic [33:0] mul_sum;
    logic [32:0] rem_sh;
    logic        fix;

    assign add_s = add_a + (add_sub ? ~add_b : add_b) + {33'd0, add_sub};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        req_next   = req_reg;
        d_next     = d_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        mag_next   = mag_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        add_a      = '0;
        add_b      = '0;
        add_sub    = 1'b0;
        mul_sum    = {1'b0, rem_reg};
        rem_sh     = {rem_reg[31:0], p_reg[63]};
        fix        = 1'b0;
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    req_next   = req;
                    state_next = U_D;
                end
            end
            U_D: begin
                add_a      = {{2{req_reg.x1[31]}}, req_reg.x1};
                add_b      = {{2{req_reg.x0[31]}}, req_reg.x0};
                add_sub    = 1'b1;
                d_next     = add_s[31:0];
                state_next = U_W;
            end
            U_W: begin
                add_a      = {{2{req_reg.w[31]}}, req_reg.w};
                add_b      = {{2{req_reg.x0[31]}}, req_reg.x0};
                add_sub    = 1'b1;
                p_next     = {32'd0, add_s[31:0]};
                state_next = U_DY;
            end
            U_DY: begin
                add_a      = {{2{req_reg.y1[31]}}, req_reg.y1};
                add_b      = {{2{req_reg.y0[31]}}, req_reg.y0};
                add_sub    = 1'b1;
                base_next  = add_s;
                neg_next   = add_s[33];
                state_next = U_ABS;
            end
            U_ABS: begin
                add_a      = '0;
                add_b      = base_reg;
                add_sub    = neg_reg;
                if (!neg_reg) begin
                    add_a = base_reg;
                    add_b = '0;
                end
                mag_next   = add_s[32:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = U_MUL;
            end
            U_MUL: begin
                add_a = {1'b0, rem_reg};
                add_b = {1'b0, mag_reg};
                if (p_reg[0]) begin
                    mul_sum = add_s;
                end
                if (cnt_reg == 6'd31) begin
                    p_next     = {mul_sum[32:1], mul_sum[0], p_reg[31:1]};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = U_DIV;
                end else begin
                    rem_next   = mul_sum[33:1];
                    p_next     = {32'd0, mul_sum[0], p_reg[31:1]};
                    cnt_next   = cnt_reg + 6'd1;
                end
            end
            U_DIV: begin
                add_a   = {1'b0, rem_sh};
                add_b   = {2'b00, d_reg};
                add_sub = 1'b1;
                rem_next = add_s[33] ? rem_sh : add_s[32:0];
                p_next   = {p_reg[62:0], ~add_s[33]};
                if (cnt_reg == 6'd63) begin
                    state_next = U_FIN;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            U_FIN: begin
                add_a      = {{2{req_reg.y0[31]}}, req_reg.y0};
                add_b      = {1'b0, p_reg[32:0]};
                add_sub    = neg_reg;
                base_next  = add_s;
                state_next = U_CORR;
            end
            U_CORR: begin
                add_a   = base_reg;
                add_b   = 34'd1;
                add_sub = neg_reg;
                if (rem_reg != '0) begin
                    fix = neg_reg ? (!base_reg[33] && base_reg != '0) : base_reg[33];
                end
                res_next   = fix ? add_s[31:0] : base_reg[31:0];
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        req_reg  <= req_next;
        d_reg    <= d_next;
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        mag_reg  <= mag_next;
        base_reg <= base_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

[rtl/channel_slew_interpolation_table_top.sv]
// Per-channel calibration table with piecewise linear interpolation.
// Input channel s_*: s_tuser[0] = op (0 append point, 1 evaluate);
//   s_tdata = chan_id, width_q, corr_in from the low bit up.
// Result channel m_*: m_tdata = corr_out, m_tuser = status. One result
//   transaction per input transaction, in order.
// One transaction at a time: s_tready is low from acceptance until the
//   result has been taken, and rises in the cycle after that handshake.
// After acceptance: a bad sector or full store goes straight to the result;
//   append reads the channel start memory from the channel downward, marking
//   each unset start, stops at the first marked channel or channel 0, then stores the point;
//   evaluate reads the start of the channel and of the next one (not on the
//   last channel of a sector), then scans points; a query between two points
//   runs a shift-add multiply and restoring divide on a single shared 34-bit adder.
// Reset: synchronous, active low. After reset the block sweeps the channel
//   start memory once (SECTORS*CPS entries, 18432) and keeps s_tready low
//   during the sweep. The point store is not cleared.
// A stalled receiver (m_tready low) holds the result and the block stays
//   busy until the result transaction completes.
`default_nettype none
module channel_slew_interpolation_table_top import cst_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // chan_id[14:0], width_q[46:15], corr_in[78:47]
    input  wire logic [0:0]  s_tuser,   // op[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // corr_out[31:0]
    output logic [2:0]       m_tuser    // status[2:0]
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A_RD   = 4'd2;
    localparam logic [3:0] S_A_CHK  = 4'd3;
    localparam logic [3:0] S_A_FIN  = 4'd4;
    localparam logic [3:0] S_E_RD0  = 4'd5;
    localparam logic [3:0] S_E_RD1  = 4'd6;
    localparam logic [3:0] S_E_STOP = 4'd7;
    localparam logic [3:0] S_E_CHK  = 4'd8;
    localparam logic [3:0] S_E_PRD  = 4'd9;
    localparam logic [3:0] S_E_PCHK = 4'd10;
    localparam logic [3:0] S_E_MD   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [CS_AW-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  count_reg [SECTORS];
    logic [CNT_W-1:0]  count_next [SECTORS];

    logic              op_reg, op_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [CH_W-1:0]   idx_reg, idx_next;
    logic signed [31:0] wq_reg, wq_next;
    logic signed [31:0] cq_reg, cq_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  stop_reg, stop_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic signed [31:0] x0_reg, x0_next;
    logic signed [31:0] y0_reg, y0_next;
    logic [31:0]       res_reg, res_next;
    logic [2:0]        st_reg, st_next;

    logic [CNT_W-1:0]  cs_mem [CS_DEPTH];
    logic [CNT_W-1:0]  cs_rdata_reg;
    logic              cs_we, cs_re;
    logic [CS_AW-1:0]  cs_waddr, cs_raddr;
    logic [CNT_W-1:0]  cs_wdata;

    logic [63:0]       pt_mem [PT_DEPTH];
    logic [63:0]       pt_rdata_reg;
    logic              pt_we, pt_re;
    logic [PT_AW-1:0]  pt_waddr, pt_raddr;

    logic [SEC_W-1:0]  in_sec;
    logic              in_bad;
    logic [CNT_W-1:0]  in_cnt;
    logic [CNT_W-1:0]  cand;
    logic signed [31:0] px, py;

    interp_req_t       ip_req;
    logic              ip_start, ip_done;
    logic [31:0]       ip_result;

    assign in_sec = s_tdata[ID_W-1:CH_W];
    assign in_bad = {1'b0, in_sec} >= (SEC_W+1)'(SECTORS);
    assign in_cnt = in_bad ? '0 : count_reg[in_sec[SC_W-1:0]];
    assign px     = pt_rdata_reg[31:0];
    assign py     = pt_rdata_reg[63:32];
    assign cand   = (cs_rdata_reg != START_UNSET) ? cs_rdata_reg : cnt_reg;
    assign ip_req = '{x0: x0_reg, y0: y0_reg, x1: px, y1: py, w: wq_reg};

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        op_next    = op_reg;
        sec_next   = sec_reg;
        ch_next    = ch_reg;
        idx_next   = idx_reg;
        wq_next    = wq_reg;
        cq_next    = cq_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        stop_next  = stop_reg;
        i_next     = i_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        cs_we      = 1'b0;
        cs_waddr   = {sec_reg, idx_reg};
        cs_wdata   = cnt_reg;
        cs_re      = 1'b0;
        cs_raddr   = {sec_reg, idx_reg};
        pt_we      = 1'b0;
        pt_waddr   = {sec_reg, cnt_reg[PIDX_W-1:0]};
        pt_re      = 1'b0;
        pt_raddr   = {sec_reg, i_reg[PIDX_W-1:0]};
        ip_start   = 1'b0;
        case (state_reg)
            S_CLR: begin
                cs_we    = 1'b1;
                cs_waddr = clr_reg;
                cs_wdata = START_UNSET;
                if (clr_reg == CS_AW'(CS_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = s_tuser[0];
                    sec_next = in_sec;
                    ch_next  = s_tdata[CH_W-1:0];
                    idx_next = s_tdata[CH_W-1:0];
                    wq_next  = s_tdata[46:15];
                    cq_next  = s_tdata[78:47];
                    cnt_next = in_cnt;
                    res_next = '0;
                    if (in_bad) begin
                        st_next    = ST_BADSECTOR;
                        state_next = S_OUT;
                    end else if (s_tuser[0] == OP_EVAL) begin
                        state_next = S_E_RD0;
                    end else if (in_cnt >= CNT_W'(PPS)) begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_A_RD;
                    end
                end
            end
            S_A_RD: begin
                cs_re      = 1'b1;
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                if (cs_rdata_reg == START_UNSET) begin
                    cs_we = 1'b1;
                    if (idx_reg == '0) begin
                        state_next = S_A_FIN;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_A_RD;
                    end
                end else begin
                    state_next = S_A_FIN;
                end
            end
            S_A_FIN: begin
                pt_we = 1'b1;
                count_next[sec_reg[SC_W-1:0]] = cnt_reg + 1'b1;
                st_next    = ST_OK;
                state_next = S_OUT;
            end
            S_E_RD0: begin
                cs_re      = 1'b1;
                cs_raddr   = {sec_reg, ch_reg};
                state_next = S_E_RD1;
            end
            S_E_RD1: begin
                n_next = cs_rdata_reg;
                if (ch_reg == CH_W'(CPS - 1)) begin
                    stop_next  = cnt_reg;
                    state_next = S_E_CHK;
                end else begin
                    cs_re      = 1'b1;
                    cs_raddr   = {sec_reg, CH_W'(ch_reg + 1'b1)};
                    state_next = S_E_STOP;
                end
            end
            S_E_STOP: begin
                stop_next  = (cand > cnt_reg) ? cnt_reg : cand;
                state_next = S_E_CHK;
            end
            S_E_CHK: begin
                if (n_reg == START_UNSET || n_reg >= stop_reg) begin
                    st_next    = ST_NODATA;
                    state_next = S_OUT;
                end else begin
                    i_next     = n_reg;
                    state_next = S_E_PRD;
                end
            end
            S_E_PRD: begin
                pt_re      = 1'b1;
                state_next = S_E_PCHK;
            end
            S_E_PCHK: begin
                if (px <= wq_reg) begin
                    x0_next = px;
                    y0_next = py;
                    if (CNT_W'(i_reg + 1'b1) == stop_reg) begin
                        res_next   = py;
                        st_next    = ST_LAST;
                        state_next = S_OUT;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_E_PRD;
                    end
                end else if (i_reg == n_reg) begin
                    st_next    = ST_NODATA;
                    state_next = S_OUT;
                end else begin
                    ip_start   = 1'b1;
                    state_next = S_E_MD;
                end
            end
            S_E_MD: begin
                if (ip_done) begin
                    res_next   = ip_result;
                    st_next    = ST_OK;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            for (int k = 0; k < SECTORS; k++) begin
                count_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        sec_reg  <= sec_next;
        ch_reg   <= ch_next;
        idx_reg  <= idx_next;
        wq_reg   <= wq_next;
        cq_reg   <= cq_next;
        cnt_reg  <= cnt_next;
        n_reg    <= n_next;
        stop_reg <= stop_next;
        i_reg    <= i_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

    always_ff @(posedge aclk) begin
        if (cs_we) begin
            cs_mem[cs_waddr] <= cs_wdata;
        end
        if (cs_re) begin
            cs_rdata_reg <= cs_mem[cs_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= {cq_reg, wq_reg};
        end
        if (pt_re) begin
            pt_rdata_reg <= pt_mem[pt_raddr];
        end
    end

    cst_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ip_start),
        .req     (ip_req),
        .done    (ip_done),
        .result  (ip_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = (op_reg == OP_APPEND) ? 32'd0 : res_reg;
    assign m_tuser  = st_reg;

endmodule
`default_nettype wire

[rtl/cst_checker.sv]
`default_nettype none
module cst_checker import cst_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second transaction while busy");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    a_zero_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NODATA || m_tuser == ST_BADSECTOR ||
        m_tuser == ST_FULL) |-> m_tdata == 32'd0)
        else $error("nonzero correction on error status");

endmodule

bind channel_slew_interpolation_table_top cst_checker u_cst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
    import cst_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    class calib_table_tracker;
        int start_of[CS_DEPTH];
        int px[PT_DEPTH];
        int py[PT_DEPTH];
        int count_of[SECTORS];
        logic [31:0] exp_corr[$];
        logic [2:0] exp_status[$];
        int errors;

        function new();
            foreach (start_of[k]) start_of[k] = -1;
            foreach (count_of[k]) count_of[k] = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return exp_corr.size();
        endfunction

        // truncating y0 + (y1-y0)*(w-x0)/(x1-x0), x0 <= w < x1
        function logic [31:0] lerp(int x0, int y0, int x1, int y1, int w);
            bit [63:0] d, w1, mag, p, q, r;
            longint dy, base;
            bit neg;
            d = 64'(longint'(x1) - longint'(x0));
            w1 = 64'(longint'(w) - longint'(x0));
            dy = longint'(y1) - longint'(y0);
            neg = dy < 0;
            mag = neg ? 64'(-dy) : 64'(dy);
            p = mag * w1;
            q = p / d;
            r = p % d;
            base = neg ? longint'(y0) - longint'(q) : longint'(y0) + longint'(q);
            if (r != 0) begin
                if (!neg && base < 0) base = base + 1;
                else if (neg && base > 0) base = base - 1;
            end
            return base[31:0];
        endfunction

        function void note_input(logic op, logic [14:0] id, int w, int c);
            int sec, ch, cnt, n, stop, i, pb, cb;
            logic [31:0] res;
            logic [2:0] st;
            sec = id / CPS;
            ch = id % CPS;
            res = '0;
            if (sec >= SECTORS) begin
                st = ST_BADSECTOR;
            end else begin
                cb = sec * CPS;
                pb = sec * PPS;
                cnt = count_of[sec];
                if (op == OP_APPEND) begin
                    if (cnt >= PPS) begin
                        st = ST_FULL;
                    end else begin
                        i = ch;
                        while (i >= 0 && start_of[cb + i] == -1) begin
                            start_of[cb + i] = cnt;
                            i--;
                        end
                        px[pb + cnt] = w;
                        py[pb + cnt] = c;
                        count_of[sec] = cnt + 1;
                        st = ST_OK;
                    end
                end else begin
                    n = start_of[cb + ch];
                    stop = cnt;
                    if (ch + 1 < CPS && start_of[cb + ch + 1] != -1)
                        stop = start_of[cb + ch + 1];
                    if (stop > cnt) stop = cnt;
                    if (n == -1 || n >= stop) begin
                        st = ST_NODATA;
                    end else begin
                        i = n;
                        while (i < stop && px[pb + i] <= w) i++;
                        if (i == n) begin
                            st = ST_NODATA;
                        end else if (i == stop) begin
                            res = py[pb + i - 1];
                            st = ST_LAST;
                        end else begin
                            res = lerp(px[pb + i - 1], py[pb + i - 1],
                                       px[pb + i], py[pb + i], w);
                            st = ST_OK;
                        end
                    end
                end
            end
            exp_corr.push_back(res);
            exp_status.push_back(st);
        endfunction

        task check_result(logic [31:0] corr, logic [2:0] status);
            logic [31:0] ec;
            logic [2:0] es;
            if (exp_corr.size() == 0) begin
                report($sformatf("unexpected result corr=%h status=%0d", corr, status));
            end else begin
                ec = exp_corr.pop_front();
                es = exp_status.pop_front();
                if (corr !== ec)
                    report($sformatf("corr_out %h, expected %h", corr, ec));
                if (status !== es)
                    report($sformatf("status %0d, expected %0d", status, es));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    calib_table_tracker sb = new();
    int idle_pct;
    int stall_pct;
    int hold_cycles;
    int quiet_cycles;

    channel_slew_interpolation_table_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // transaction monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser[0], s_tdata[14:0], s_tdata[46:15], s_tdata[78:47]);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic op, input int id, input logic [31:0] w,
                             input logic [31:0] c);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {1'b0, c, w, id[14:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain(input int settle);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_width();
        case ($urandom_range(3))
            0: return $urandom();
            default: return 32'($signed($urandom_range(8191)) - 4096);
        endcase
    endfunction

    task automatic send_random();
        int sec, ch, id;
        logic op;
        if ($urandom_range(19) == 0) begin
            id = $urandom_range(32767);
            if (id / CPS == SECTORS - 1) id = id % CPS;
        end else begin
            sec = $urandom_range(SECTORS - 2);
            case ($urandom_range(9))
                0: ch = $urandom_range(CPS - 1);
                1: ch = CPS - 1;
                default: ch = $urandom_range(7);
            endcase
            id = sec * CPS + ch;
        end
        op = ($urandom_range(99) < 40) ? OP_APPEND : OP_EVAL;
        send_item(op, id, rand_width(), $urandom());
    endtask

    initial begin
        int k;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // directed
        send_item(OP_EVAL, 0, 0, 0);
        send_item(OP_APPEND, SECTORS * CPS, 0, 0);
        send_item(OP_EVAL, 32767, 32'h7fffffff, 32'hffffffff);
        send_item(OP_APPEND, 2, 32'h80000000, 32'h7fffffff);
        send_item(OP_APPEND, 2, 32'h0, 32'h80000000);
        send_item(OP_APPEND, 2, 32'h7fffffff, 32'h7fffffff);
        send_item(OP_EVAL, 2, 32'h80000000, 0);
        send_item(OP_EVAL, 2, 32'h80000001, 0);
        send_item(OP_EVAL, 2, 32'hffffffff, 0);
        send_item(OP_EVAL, 2, 32'h00000001, 0);
        send_item(OP_EVAL, 2, 32'h7fffffff, 0);
        send_item(OP_EVAL, 0, 0, 0);
        send_item(OP_EVAL, 5, 0, 0);
        send_item(OP_APPEND, CPS + CPS - 1, 100, -5);
        send_item(OP_APPEND, CPS + CPS - 1, 200, 7);
        send_item(OP_EVAL, CPS + CPS - 1, 99, 0);
        send_item(OP_EVAL, CPS + CPS - 1, 150, 0);
        send_item(OP_EVAL, CPS + CPS - 1, 500, 0);
        send_item(OP_EVAL, CPS + 3, 150, 0);
        send_item(OP_APPEND, 1, 10, 10);
        send_item(OP_EVAL, 1, 10, 0);
        send_item(OP_EVAL, 2, 0, 0);

        // a run of points on the last channel of the last sector
        for (k = 0; k < 8; k++)
            send_item(OP_APPEND, (SECTORS - 1) * CPS + CPS - 1, k * 16, $urandom());
        send_item(OP_APPEND, (SECTORS - 1) * CPS, 0, 0);
        send_item(OP_EVAL, (SECTORS - 1) * CPS + CPS - 1, 24007, 0);
        send_item(OP_EVAL, (SECTORS - 1) * CPS + 5, 100000, 0);
        drain(300);

        for (k = 0; k < 455; k++) send_random();

        idle_pct = 64;
        for (k = 0; k < 455; k++) send_random();
        drain(300);

        idle_pct = 0;
        stall_pct = 64;
        hold_cycles = 3000;
        for (k = 0; k < 455; k++) send_random();

        idle_pct = 12;
        stall_pct = 12;
        for (k = 0; k < 455; k++) send_random();

        drain(300);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
